// ===== hw/rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tick task event scheduler package
// Shared sizes, command codes, table entry layout and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int EV_W   = 8;
    localparam int TIME_W = 16;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_SET      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;

    typedef enum logic [1:0] {
        WR_SET   = 2'd0,
        WR_AGE   = 2'd1,
        WR_REARM = 2'd2,
        WR_MOVE  = 2'd3
    } wr_op_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic              runnable;
    } entry_t;

    typedef struct packed {
        logic   load;
        logic   idx_clr;
        logic   idx_inc;
        logic   rd_en;
        logic   rd_last;
        logic   wr_en;
        wr_op_t wr_op;
        logic   wr_at_count;
        logic   cnt_inc;
        logic   cnt_dec;
        logic   push;
        logic   flush;
    } tts_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             ev_zero;
        logic             tick;
        logic             idx_end;
        logic             full;
        logic             match;
        logic             runnable;
        logic             period_zero;
        logic             res_full;
    } tts_stat_t;

endpackage

// ===== hw/rtl/tts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tick task event scheduler controller
// Sequences the table scans for set, delete, ageing and firing, one entry
// read and one entry examined at a time.
// ----------------------------------------------------------------------------
module tts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tts_pkg::tts_stat_t sts,
    output tts_pkg::tts_ctrl_t ctl
);
    import tts_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_DECODE  = 13'b0000000000010,
        ST_SET_RD  = 13'b0000000000100,
        ST_SET_EX  = 13'b0000000001000,
        ST_DEL_RD  = 13'b0000000010000,
        ST_DEL_EX  = 13'b0000000100000,
        ST_LAST_RD = 13'b0000001000000,
        ST_MOVE    = 13'b0000010000000,
        ST_AGE_RD  = 13'b0000100000000,
        ST_AGE_EX  = 13'b0001000000000,
        ST_FIRE_RD = 13'b0010000000000,
        ST_FIRE_EX = 13'b0100000000000,
        ST_FLUSH   = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.wr_op  = WR_SET;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (sts.command)
                    CMD_SET:      state_next = sts.ev_zero ? ST_IDLE : ST_SET_RD;
                    CMD_DELETE:   state_next = ST_DEL_RD;
                    CMD_DISPATCH: state_next = sts.tick ? ST_AGE_RD : ST_FIRE_RD;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_SET_RD:
            begin
                if (sts.idx_end)
                begin
                    if (!sts.full)
                    begin
                        ctl.wr_en       = 1'b1;
                        ctl.wr_op       = WR_SET;
                        ctl.wr_at_count = 1'b1;
                        ctl.cnt_inc     = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ST_SET_EX;
                end
            end
            ST_SET_EX:
            begin
                if (sts.match)
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.wr_op  = WR_SET;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_SET_RD;
                end
            end
            ST_DEL_RD:
            begin
                if (sts.idx_end)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ST_DEL_EX;
                end
            end
            ST_DEL_EX:
            begin
                if (sts.match)
                begin
                    state_next = ST_LAST_RD;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_DEL_RD;
                end
            end
            ST_LAST_RD:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_last = 1'b1;
                state_next  = ST_MOVE;
            end
            ST_MOVE:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_op   = WR_MOVE;
                ctl.cnt_dec = 1'b1;
                if (sts.command == CMD_DISPATCH)
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AGE_RD:
            begin
                if (sts.idx_end)
                begin
                    ctl.idx_clr = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ST_AGE_EX;
                end
            end
            ST_AGE_EX:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_op   = WR_AGE;
                ctl.idx_inc = 1'b1;
                state_next  = ST_AGE_RD;
            end
            ST_FIRE_RD:
            begin
                if (sts.idx_end || sts.res_full)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    state_next = ST_FIRE_EX;
                end
            end
            ST_FIRE_EX:
            begin
                if (!sts.runnable)
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
                else if (sts.period_zero)
                begin
                    ctl.push   = 1'b1;
                    state_next = ST_LAST_RD;
                end
                else
                begin
                    ctl.push    = 1'b1;
                    ctl.wr_en   = 1'b1;
                    ctl.wr_op   = WR_REARM;
                    ctl.idx_inc = 1'b1;
                    state_next  = ST_FIRE_RD;
                end
            end
            ST_FLUSH:
            begin
                ctl.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tts_datapath.sv =====
// ----------------------------------------------------------------------------
// Tick task event scheduler datapath
// Holds the task table memory, the entry count, the scan index, the latched
// command and the one-deep holding register that lets the final result of a
// dispatch carry its last flag.
// ----------------------------------------------------------------------------
module tts_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tts_pkg::CMD_W-1:0]         command,
    input  logic [tts_pkg::EV_W-1:0]          event_id,
    input  logic [tts_pkg::TIME_W-1:0]        start_delay,
    input  logic [tts_pkg::TIME_W-1:0]        repeat_period,
    input  logic                              tick_seen,
    input  tts_pkg::tts_ctrl_t                ctl,
    output tts_pkg::tts_stat_t                sts,
    output logic                              result_valid,
    output logic [tts_pkg::EV_W-1:0]          fired_event,
    output logic                              last_fired
);
    import tts_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [EV_W-1:0]   ev_reg;
    logic [TIME_W-1:0] dly_reg;
    logic [TIME_W-1:0] per_reg;
    logic              tick_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] index_reg;
    logic [CNT_W-1:0] index_next;
    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;

    logic            pend_valid_reg;
    logic            pend_valid_next;
    logic [EV_W-1:0] pend_event_reg;
    logic [EV_W-1:0] pend_event_next;

    logic            result_valid_reg;
    logic            result_valid_next;
    logic [EV_W-1:0] fired_event_reg;
    logic [EV_W-1:0] fired_event_next;
    logic            last_fired_reg;
    logic            last_fired_next;

    logic [IDX_W-1:0] last_index;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    assign last_index = count_reg[IDX_W-1:0] - IDX_W'(1);
    assign rd_addr    = ctl.rd_last ? last_index : index_reg[IDX_W-1:0];
    assign wr_addr    = ctl.wr_at_count ? count_reg[IDX_W-1:0] : index_reg[IDX_W-1:0];

    always_comb
    begin
        wr_data = rdata_reg;
        unique case (ctl.wr_op)
            WR_SET:
            begin
                wr_data.event_id = ev_reg;
                wr_data.delay    = dly_reg;
                wr_data.period   = per_reg;
                wr_data.runnable = (dly_reg == '0);
            end
            WR_AGE:
            begin
                if (rdata_reg.delay == '0)
                begin
                    wr_data.runnable = 1'b1;
                end
                else
                begin
                    wr_data.delay = rdata_reg.delay - TIME_W'(1);
                end
            end
            WR_REARM:
            begin
                wr_data.runnable = 1'b0;
                if (rdata_reg.delay == '0)
                begin
                    wr_data.delay = rdata_reg.period - TIME_W'(1);
                end
            end
            WR_MOVE:
            begin
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= command;
            ev_reg   <= event_id;
            dly_reg  <= start_delay;
            per_reg  <= repeat_period;
            tick_reg <= tick_seen;
        end
        fired_event_reg <= fired_event_next;
        last_fired_reg  <= last_fired_next;
        pend_event_reg  <= pend_event_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        index_next = index_reg;
        if (ctl.load || ctl.idx_clr)
        begin
            index_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            index_next = index_reg + CNT_W'(1);
        end

        res_next = res_reg;
        if (ctl.load)
        begin
            res_next = '0;
        end
        else if (ctl.push)
        begin
            res_next = res_reg + RES_W'(1);
        end

        pend_valid_next   = pend_valid_reg;
        pend_event_next   = pend_event_reg;
        result_valid_next = 1'b0;
        fired_event_next  = pend_event_reg;
        last_fired_next   = 1'b0;
        if (ctl.push)
        begin
            result_valid_next = pend_valid_reg;
            pend_valid_next   = 1'b1;
            pend_event_next   = rdata_reg.event_id;
        end
        else if (ctl.flush)
        begin
            result_valid_next = pend_valid_reg;
            last_fired_next   = 1'b1;
            pend_valid_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            index_reg        <= '0;
            res_reg          <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            index_reg        <= index_next;
            res_reg          <= res_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign sts.command     = cmd_reg;
    assign sts.ev_zero     = (ev_reg == '0);
    assign sts.tick        = tick_reg;
    assign sts.idx_end     = (index_reg >= count_reg);
    assign sts.full        = (count_reg == CNT_W'(TABLE_DEPTH));
    assign sts.match       = (rdata_reg.event_id == ev_reg);
    assign sts.runnable    = rdata_reg.runnable;
    assign sts.period_zero = (rdata_reg.period == '0);
    assign sts.res_full    = (res_reg == RES_W'(MAX_RESULTS));

    assign result_valid = result_valid_reg;
    assign fired_event  = fired_event_reg;
    assign last_fired   = last_fired_reg;

    // The table never holds more entries than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

    // An append is only ever issued while a slot is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.cnt_inc |-> (count_reg < CNT_W'(TABLE_DEPTH)))
    else $error("append into a full table");

    // A result that is not the final one always has a successor held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !last_fired_reg) |-> pend_valid_reg)
    else $error("non-final result without a following event");

    // A newly fired event releases the held one as a non-final transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push && pend_valid_reg) |=> (result_valid_reg && !last_fired_reg))
    else $error("held event not released on fire");

endmodule

// ===== hw/rtl/tick_task_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// Tick task event scheduler
// Command-driven table of up to sixteen tasks with delay and period, which
// ages the table on a tick and reports runnable events on dispatch.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the command has finished. The table is visited one entry at a time:
// each entry is read, then examined and written back. A set or delete scans
// the entries in order until it finds a match or reaches the end of the
// table. A set overwrites the matching entry, or else appends one while a
// slot is free; a delete moves the last entry into the freed slot. A
// dispatch first ages every entry when a tick was seen, then walks the table
// and fires each runnable entry. A fired one-shot task is removed by moving
// the last entry into its slot, and that entry is skipped in this walk; the
// walk stops after sixteen events. Each fired event appears on fired_event
// for exactly one cycle with result_valid high, and last_fired marks the
// final transfer of the dispatch. The receiver cannot stall, so it must take
// every transfer in the cycle it is shown; the final transfer appears in the
// same cycle in which busy falls.
// ----------------------------------------------------------------------------
module tick_task_event_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tts_pkg::CMD_W-1:0]  command,
    input  logic [tts_pkg::EV_W-1:0]   event_id,
    input  logic [tts_pkg::TIME_W-1:0] start_delay,
    input  logic [tts_pkg::TIME_W-1:0] repeat_period,
    input  logic                       tick_seen,
    output logic                       result_valid,
    output logic [tts_pkg::EV_W-1:0]   fired_event,
    output logic                       last_fired
);
    import tts_pkg::*;

    tts_ctrl_t ctl;
    tts_stat_t sts;

    tts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    tts_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .event_id      (event_id),
        .start_delay   (start_delay),
        .repeat_period (repeat_period),
        .tick_seen     (tick_seen),
        .ctl           (ctl),
        .sts           (sts),
        .result_valid  (result_valid),
        .fired_event   (fired_event),
        .last_fired    (last_fired)
    );

endmodule
